// ===== design/ifmt_pkg.sv =====
// Shared types, character codes and helpers of the integer-to-ASCII field formatter.
package ifmt_pkg;

    // Default parameter values of the top level and the digit unit.
    localparam int VALUE_BITS_DEF         = 64;
    localparam int MAX_FIELD_WIDTH_DEF    = 63;
    localparam int DIGIT_BUFFER_DEPTH_DEF = 23;

    // Radix select codes; any other code selects hexadecimal.
    localparam logic [1:0] BASE_OCT = 2'd0;
    localparam logic [1:0] BASE_DEC = 2'd1;

    // ASCII codes used by the formatter.
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] CH_LOWER_X = 8'h78;

    // One number with its conversion settings.
    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  base_select;
        logic        is_signed;
        logic        left_align;
        logic        force_sign;
        logic        space_sign;
        logic        alternate_prefix;
        logic        zero_pad;
        logic        upper_case;
        logic [5:0]  field_width;
        logic [5:0]  min_chars;
    } ifmt_number_t;

    // One formatted character.
    typedef struct packed {
        logic [7:0] character;
        logic       last;
        logic [6:0] char_count;
    } ifmt_result_t;

    // Operations of the shared digit unit.
    typedef enum logic [2:0] {
        OP_IDLE,
        OP_LOAD_BIN,
        OP_LOAD_ACC,
        OP_DABBLE,
        OP_EXTRACT
    } ifmt_op_t;

    // Command from the sequencer to the digit unit.
    typedef struct packed {
        ifmt_op_t op;
        logic     octal;
    } ifmt_cmd_t;

    // Status from the digit unit back to the sequencer.
    typedef struct packed {
        logic [3:0] digit;
        logic       rest_zero;
    } ifmt_stat_t;

    // ASCII character of one digit value in the selected letter case.
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic up);
        logic [7:0] ch;
        begin
            if (d < 4'd10)
            begin
                ch = CH_ZERO + {4'd0, d};
            end
            else
            begin
                ch = (up ? CH_UPPER_A : CH_LOWER_A) + {4'd0, d} - 8'd10;
            end
            return ch;
        end
    endfunction

endpackage

// ===== design/ifmt_digit_unit.sv =====
// Shared digit unit: binary-to-BCD shift-add-3 steps and low-digit extraction.
module ifmt_digit_unit
    import ifmt_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int ACC_BITS   = 80
)
(
    input  logic                  clk,
    input  ifmt_cmd_t             cmd,
    input  logic [VALUE_BITS-1:0] load_value,
    output ifmt_stat_t            stat
);

    localparam int NBCD = ACC_BITS / 4;

    logic [VALUE_BITS-1:0] bin_reg;
    logic [VALUE_BITS-1:0] bin_next;
    logic [ACC_BITS-1:0]   acc_reg;
    logic [ACC_BITS-1:0]   acc_next;
    logic [ACC_BITS-1:0]   acc_adj;
    logic [ACC_BITS-1:0]   acc_shift;

    // Add three to every BCD digit of five or more before the next shift.
    always_comb
    begin
        for (int j = 0; j < NBCD; j++)
        begin
            acc_adj[4*j +: 4] = (acc_reg[4*j +: 4] >= 4'd5) ? acc_reg[4*j +: 4] + 4'd3
                                                            : acc_reg[4*j +: 4];
        end
    end

    // Low digit and the word left after it is removed.
    assign acc_shift      = cmd.octal ? (acc_reg >> 3) : (acc_reg >> 4);
    assign stat.digit     = cmd.octal ? {1'b0, acc_reg[2:0]} : acc_reg[3:0];
    assign stat.rest_zero = (acc_shift == '0);

    // Next value of the working registers.
    always_comb
    begin
        bin_next = bin_reg;
        acc_next = acc_reg;
        case (cmd.op)
            OP_LOAD_BIN:
            begin
                bin_next = load_value;
                acc_next = '0;
            end
            OP_LOAD_ACC:
            begin
                acc_next = {{(ACC_BITS-VALUE_BITS){1'b0}}, load_value};
            end
            OP_DABBLE:
            begin
                acc_next = {acc_adj[ACC_BITS-2:0], bin_reg[VALUE_BITS-1]};
                bin_next = {bin_reg[VALUE_BITS-2:0], 1'b0};
            end
            OP_EXTRACT:
            begin
                acc_next = acc_shift;
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        acc_reg <= acc_next;
    end

endmodule

// ===== design/integer_to_ascii_field_formatter_core.sv =====
// Top level of the integer-to-ASCII field formatter: sequencer, digit buffer and output.
//
// Usage: drive a number and its settings on number and raise start while busy is low;
// the word is taken at that clock edge and busy rises on the next cycle. The block
// answers with one ASCII character per cycle on result, each marked by strobe for
// exactly one cycle; the final character carries last and the total count in
// char_count (char_count is zero on every other character). The receiver must take
// every character as it comes; it cannot hold results off.
// Steps: the word is taken, then shift-add-3 steps over all value bits for decimal
// (none for octal or hex), digit extraction in the digit unit (at most
// DIGIT_BUFFER_DEPTH-1 digits), the sizing states ST_ZEROS, ST_SPACES and
// ST_BOUNDS, then the characters one per cycle. The shared digit unit and the
// one-character-per-cycle output set how long a number takes. busy falls in the
// cycle that carries the last character, and the next word can be taken at the
// edge that ends it. At reset the sequencer returns to idle and no character is
// pending.
module integer_to_ascii_field_formatter_core
    import ifmt_pkg::*;
#(
    parameter int VALUE_BITS         = VALUE_BITS_DEF,
    parameter int MAX_FIELD_WIDTH    = MAX_FIELD_WIDTH_DEF,
    parameter int DIGIT_BUFFER_DEPTH = DIGIT_BUFFER_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  ifmt_number_t number,
    output ifmt_result_t result,
    output logic         strobe
);

    localparam int NDIG     = DIGIT_BUFFER_DEPTH - 1;
    localparam int LEN_W    = $clog2(NDIG + 1);
    localparam int IDX_W    = $clog2(NDIG);
    localparam int NBCD     = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int ACC_BITS = 4 * NBCD;
    localparam int CNT_W    = $clog2(VALUE_BITS);
    localparam logic [5:0] MAXW = 6'(MAX_FIELD_WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DABBLE,
        ST_EXTRACT,
        ST_ZEROS,
        ST_SPACES,
        ST_BOUNDS,
        ST_EMIT
    } state_t;

    state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic         oct_reg, oct_next;
    logic         la_reg, la_next;
    logic         zp_reg, zp_next;
    logic         up_reg, up_next;
    logic [5:0]   width_reg, width_next;
    logic [5:0]   minc_reg, minc_next;
    logic [1:0]   plen_reg, plen_next;
    logic [7:0]   pre0_reg, pre0_next;
    logic [7:0]   pre1_reg, pre1_next;
    logic [5:0]   lp_reg, lp_next;
    logic [5:0]   zeros_reg, zeros_next;
    logic [5:0]   spaces_reg, spaces_next;
    logic [5:0]   total_reg, total_next;
    logic [5:0]   b1_reg, b1_next;
    logic [5:0]   b2_reg, b2_next;
    logic [5:0]   b3_reg, b3_next;
    logic [5:0]   b4_reg, b4_next;
    logic [5:0]   pos_reg, pos_next;
    ifmt_result_t result_reg, result_next;
    logic         strobe_reg, strobe_next;

    logic [3:0]   dig_buf [NDIG];
    logic         dig_we;

    ifmt_cmd_t    cmd;
    ifmt_stat_t   stat;

    logic                  accept;
    logic [VALUE_BITS-1:0] raw;
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
    logic [5:0]            len6;
    logic [5:0]            target;
    logic [6:0]            used7;
    logic [5:0]            used;
    logic [5:0]            dig_off;
    logic                  is_last;
    logic [7:0]            ch;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign result = result_reg;
    assign strobe = strobe_reg;

    // Magnitude of the incoming number within VALUE_BITS.
    assign raw  = number.value[VALUE_BITS-1:0];
    assign neg  = number.is_signed && raw[VALUE_BITS-1];
    assign mag  = neg ? (~raw + 1'b1) : raw;
    assign len6 = 6'(len_reg);

    ifmt_digit_unit #(
        .VALUE_BITS (VALUE_BITS),
        .ACC_BITS   (ACC_BITS)
    ) u_digit (
        .clk        (clk),
        .cmd        (cmd),
        .load_value (mag),
        .stat       (stat)
    );

    // Zero count target and the size of the printed body.
    assign target  = (len6 < minc_reg) ? minc_reg : ((zp_reg && !la_reg) ? width_reg : 6'd0);
    assign used7   = {1'b0, lp_reg} + {1'b0, zeros_reg};
    assign used    = used7[5:0];

    // Character at the current output position.
    assign dig_off = b4_reg - 6'd1 - pos_reg;
    assign is_last = (pos_reg == total_reg - 6'd1);
    always_comb
    begin
        if (pos_reg < b1_reg)
        begin
            ch = CH_SPACE;
        end
        else if (pos_reg < b2_reg)
        begin
            ch = (pos_reg == b1_reg) ? pre0_reg : pre1_reg;
        end
        else if (pos_reg < b3_reg)
        begin
            ch = CH_ZERO;
        end
        else if (pos_reg < b4_reg)
        begin
            ch = digit_char(dig_buf[dig_off[IDX_W-1:0]], up_reg);
        end
        else
        begin
            ch = CH_SPACE;
        end
    end

    // Sequencer next-state logic.
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        len_next    = len_reg;
        oct_next    = oct_reg;
        la_next     = la_reg;
        zp_next     = zp_reg;
        up_next     = up_reg;
        width_next  = width_reg;
        minc_next   = minc_reg;
        plen_next   = plen_reg;
        pre0_next   = pre0_reg;
        pre1_next   = pre1_reg;
        lp_next     = lp_reg;
        zeros_next  = zeros_reg;
        spaces_next = spaces_reg;
        total_next  = total_reg;
        b1_next     = b1_reg;
        b2_next     = b2_reg;
        b3_next     = b3_reg;
        b4_next     = b4_reg;
        pos_next    = pos_reg;
        result_next = result_reg;
        strobe_next = 1'b0;
        dig_we      = 1'b0;
        cmd.op      = OP_IDLE;
        cmd.octal   = oct_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    oct_next   = (number.base_select == BASE_OCT);
                    la_next    = number.left_align;
                    zp_next    = number.zero_pad;
                    up_next    = number.upper_case;
                    width_next = (number.field_width > MAXW) ? MAXW : number.field_width;
                    minc_next  = (number.min_chars > MAXW) ? MAXW : number.min_chars;
                    len_next   = '0;
                    cnt_next   = CNT_W'(VALUE_BITS - 1);
                    pre0_next  = CH_ZERO;
                    pre1_next  = number.upper_case ? CH_UPPER_X : CH_LOWER_X;
                    plen_next  = 2'd0;
                    // Prefix by priority: sign first, then the radix marker.
                    if (neg)
                    begin
                        plen_next = 2'd1;
                        pre0_next = CH_MINUS;
                    end
                    else if (number.is_signed && number.force_sign)
                    begin
                        plen_next = 2'd1;
                        pre0_next = CH_PLUS;
                    end
                    else if (number.is_signed && number.space_sign)
                    begin
                        plen_next = 2'd1;
                        pre0_next = CH_SPACE;
                    end
                    else if (number.alternate_prefix && (number.base_select == BASE_OCT))
                    begin
                        plen_next = 2'd1;
                    end
                    else if (number.alternate_prefix && (number.base_select != BASE_DEC))
                    begin
                        plen_next = 2'd2;
                    end
                    if (number.base_select == BASE_DEC)
                    begin
                        cmd.op     = OP_LOAD_BIN;
                        state_next = ST_DABBLE;
                    end
                    else
                    begin
                        cmd.op     = OP_LOAD_ACC;
                        state_next = ST_EXTRACT;
                    end
                end
            end
            ST_DABBLE:
            begin
                cmd.op    = OP_DABBLE;
                cmd.octal = 1'b0;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_EXTRACT;
                end
            end
            ST_EXTRACT:
            begin
                cmd.op   = OP_EXTRACT;
                dig_we   = 1'b1;
                len_next = len_reg + 1'b1;
                if (stat.rest_zero || (len_reg == LEN_W'(NDIG - 1)))
                begin
                    state_next = ST_ZEROS;
                end
            end
            ST_ZEROS:
            begin
                lp_next    = len6 + {4'd0, plen_reg};
                zeros_next = (target > (len6 + {4'd0, plen_reg}))
                           ? target - (len6 + {4'd0, plen_reg}) : 6'd0;
                state_next = ST_SPACES;
            end
            ST_SPACES:
            begin
                spaces_next = (width_reg > used) ? width_reg - used : 6'd0;
                total_next  = (width_reg > used) ? width_reg : used;
                state_next  = ST_BOUNDS;
            end
            ST_BOUNDS:
            begin
                b1_next    = la_reg ? 6'd0 : spaces_reg;
                b2_next    = (la_reg ? 6'd0 : spaces_reg) + {4'd0, plen_reg};
                b3_next    = (la_reg ? 6'd0 : spaces_reg) + {4'd0, plen_reg} + zeros_reg;
                b4_next    = (la_reg ? 6'd0 : spaces_reg) + {4'd0, plen_reg} + zeros_reg
                           + len6;
                pos_next   = 6'd0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                strobe_next            = 1'b1;
                result_next.character  = ch;
                result_next.last       = is_last;
                result_next.char_count = is_last ? {1'b0, total_reg} : 7'd0;
                pos_next               = pos_reg + 6'd1;
                if (is_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
            cnt_reg    <= '0;
            len_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            cnt_reg    <= cnt_next;
            len_reg    <= len_next;
        end
    end

    // Settings, sizes and output word need no reset.
    always_ff @(posedge clk)
    begin
        oct_reg    <= oct_next;
        la_reg     <= la_next;
        zp_reg     <= zp_next;
        up_reg     <= up_next;
        width_reg  <= width_next;
        minc_reg   <= minc_next;
        plen_reg   <= plen_next;
        pre0_reg   <= pre0_next;
        pre1_reg   <= pre1_next;
        lp_reg     <= lp_next;
        zeros_reg  <= zeros_next;
        spaces_reg <= spaces_next;
        total_reg  <= total_next;
        b1_reg     <= b1_next;
        b2_reg     <= b2_next;
        b3_reg     <= b3_next;
        b4_reg     <= b4_next;
        pos_reg    <= pos_next;
        result_reg <= result_next;
    end

    // Digit buffer, least significant digit first.
    always_ff @(posedge clk)
    begin
        if (dig_we)
        begin
            dig_buf[len_reg[IDX_W-1:0]] <= stat.digit;
        end
    end

endmodule
